// File: src/sensor_velocity_accel_estimator_macros.svh
// Assertion macros used by the checker file of the velocity and acceleration estimator.
`ifndef SENSOR_VELOCITY_ACCEL_ESTIMATOR_MACROS_SVH
`define SENSOR_VELOCITY_ACCEL_ESTIMATOR_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SVAE_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SVAE_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sva_pkg.sv
// Types, constants and helpers shared by the estimator modules.
package sva_pkg;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W = 48;
	localparam int RAW_W = 32;
	localparam int DT_W = 16;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int A_W = 50;
	localparam int M_W = 2 * FRAC_BITS + 9;
	localparam int D_W = CFG_W + 12;
	localparam int P_W = A_W + M_W;
	localparam int CNT_W = $clog2(P_W);
	localparam int SUM_W = 52;

	localparam logic [2:0] KIND_DIGITAL = 3'd0;
	localparam logic [2:0] KIND_SONAR = 3'd1;
	localparam logic [2:0] KIND_ENCODER = 3'd2;
	localparam logic [2:0] KIND_IME = 3'd3;
	localparam logic [2:0] KIND_POT = 3'd4;
	localparam logic [2:0] KIND_GYRO = 3'd5;
	localparam logic [2:0] KIND_LIGHT = 3'd6;
	localparam logic [2:0] KIND_CUSTOM = 3'd7;

	localparam logic [IDX_W-1:0] REG_KIND = 3'd0;
	localparam logic [IDX_W-1:0] REG_REVERSE = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 3'd2;
	localparam logic [IDX_W-1:0] REG_SONAR_MIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_SONAR_MAX = 3'd4;

	typedef logic [1:0] md_sel_t;
	localparam md_sel_t SEL_CONV = 2'd0;
	localparam md_sel_t SEL_VEL = 2'd1;
	localparam md_sel_t SEL_ACC = 2'd2;

	typedef struct packed {
		logic load_in;
		logic md_start;
		md_sel_t md_sel;
		logic commit_conv;
		logic commit_vel;
		logic commit_acc;
		logic load_out;
	} sva_cmd_t;

	typedef struct packed {
		logic md_done;
		logic out_busy;
	} sva_stat_t;

	function automatic logic signed [VAL_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] pos_lim;
		logic signed [SUM_W-1:0] neg_lim;
		pos_lim = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
		neg_lim = ~pos_lim;
		if (x > pos_lim) begin
			return pos_lim[VAL_W-1:0];
		end else if (x < neg_lim) begin
			return neg_lim[VAL_W-1:0];
		end
		return x[VAL_W-1:0];
	endfunction
endpackage

// File: src/sva_muldiv.sv
// Serial multiply then restoring divide with saturated signed quotient.
module sva_muldiv
	import sva_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [A_W-1:0] a,
	input logic [M_W-1:0] m,
	input logic [D_W-1:0] den,
	output logic done,
	output logic signed [VAL_W-1:0] q
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic neg_q;
	logic [A_W-1:0] mag_q;
	logic [M_W-1:0] m_q;
	logic [D_W-1:0] den_q;
	logic [P_W-1:0] nq_q;
	logic [D_W-1:0] rem_q;
	logic [D_W:0] rem_sh;
	logic rem_ge;
	logic [VAL_W-1:0] lim;
	logic ovf;
	logic [VAL_W-1:0] qmag;

	assign rem_sh = {rem_q, nq_q[P_W-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						cnt_q <= CNT_W'(M_W - 1);
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
						cnt_q <= CNT_W'(P_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q <= a[A_W-1];
			mag_q <= a[A_W-1] ? A_W'(-a) : A_W'(a);
			m_q <= m;
			den_q <= (den == '0) ? D_W'(1) : den;
			nq_q <= '0;
			rem_q <= '0;
		end else if (state_q == ST_MUL) begin
			nq_q <= {nq_q[P_W-2:0], 1'b0}
				+ (m_q[cnt_q[$clog2(M_W)-1:0]] ? P_W'(mag_q) : P_W'(0));
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? D_W'(rem_sh - {1'b0, den_q}) : rem_sh[D_W-1:0];
			nq_q <= {nq_q[P_W-2:0], rem_ge};
		end
	end

	assign lim = neg_q ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
	assign ovf = (|nq_q[P_W-1:VAL_W]) || (nq_q[VAL_W-1:0] > lim);
	assign qmag = ovf ? lim : nq_q[VAL_W-1:0];
	assign q = neg_q ? $signed(-qmag) : $signed(qmag);
	assign done = done_q;
endmodule

// File: src/sva_datapath.sv
// Datapath: configuration registers, conversion, history, filters and output register.
module sva_datapath
	import sva_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic [RAW_W+DT_W-1:0] s_tdata,
	input logic m_tready,
	output logic m_tvalid,
	output logic [3*VAL_W-1:0] m_tdata,
	input sva_cmd_t cmd,
	output sva_stat_t stat
);
	localparam logic signed [A_W-1:0] ONE_A = A_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] POT_FULL = SUM_W'(260) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] LIGHT_FULL = SUM_W'(4095) << FRAC_BITS;

	logic [2:0] kind_q;
	logic rev_q;
	logic [CFG_W-1:0] scale_q;
	logic [15:0] smin_q;
	logic [15:0] smax_q;

	logic signed [RAW_W-1:0] raw_q;
	logic [DT_W-1:0] dt_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] newest_q;
	logic signed [VAL_W-1:0] prev_q;
	logic hist_q;
	logic signed [VAL_W-1:0] vel_q;
	logic signed [VAL_W-1:0] acc_q;
	logic signed [VAL_W-1:0] vel_new_q;
	logic out_valid_q;
	logic [3*VAL_W-1:0] out_data_q;

	logic signed [A_W-1:0] raw_a;
	logic signed [A_W-1:0] conv_a;
	logic [M_W-1:0] conv_m;
	logic [D_W-1:0] conv_den;
	logic signed [A_W-1:0] md_a;
	logic [M_W-1:0] md_m;
	logic [D_W-1:0] md_den;
	logic md_done;
	logic signed [VAL_W-1:0] md_q;
	logic signed [SUM_W-1:0] q_w;
	logic signed [VAL_W-1:0] conv_val;
	logic signed [SUM_W-1:0] vel_w;
	logic signed [SUM_W-1:0] vel_sum;
	logic signed [SUM_W-1:0] acc_sum;
	logic [D_W-1:0] dt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_DIGITAL;
			rev_q <= 1'b0;
			scale_q <= CFG_W'(1) << FRAC_BITS;
			smin_q <= 16'd0;
			smax_q <= 16'd400;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KIND: kind_q <= cfg_data[2:0];
				REG_REVERSE: rev_q <= cfg_data[0];
				REG_SCALE: scale_q <= cfg_data;
				REG_SONAR_MIN: smin_q <= cfg_data[15:0];
				REG_SONAR_MAX: smax_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign raw_a = {{(A_W-RAW_W){raw_q[RAW_W-1]}}, raw_q};
	assign dt_d = D_W'(dt_q);

	always_comb begin
		conv_a = raw_a;
		conv_m = M_W'(1);
		conv_den = D_W'(1);
		case (kind_q)
			KIND_DIGITAL: begin
				conv_a = ((raw_q == '0) != rev_q) ? ONE_A : '0;
			end
			KIND_SONAR: begin
				if (rev_q) begin
					conv_a = A_W'(smax_q) - raw_a + A_W'(smin_q);
				end
				conv_m = M_W'(scale_q);
			end
			KIND_ENCODER: begin
				conv_m = M_W'(1) << (2 * FRAC_BITS);
				conv_den = D_W'(scale_q);
			end
			KIND_IME: begin
				conv_m = M_W'(360) << (2 * FRAC_BITS);
				conv_den = D_W'(scale_q);
			end
			KIND_POT: begin
				conv_m = M_W'(260) << (2 * FRAC_BITS);
				conv_den = {scale_q, 12'd0} - D_W'(scale_q);
			end
			KIND_GYRO: begin
				conv_a = rev_q ? -raw_a : raw_a;
			end
			KIND_LIGHT: begin
				conv_m = M_W'(1) << FRAC_BITS;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		md_a = conv_a;
		md_m = conv_m;
		md_den = conv_den;
		case (cmd.md_sel)
			SEL_VEL: begin
				md_a = A_W'(newest_q) - A_W'(prev_q);
				md_m = M_W'(500);
				md_den = {dt_d[D_W-2:0], 1'b0} + dt_d;
			end
			SEL_ACC: begin
				md_a = A_W'(vel_new_q) - A_W'(vel_q);
				md_m = M_W'(1);
				md_den = dt_d;
			end
			default: begin
			end
		endcase
	end

	sva_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.md_start),
		.a(md_a),
		.m(md_m),
		.den(md_den),
		.done(md_done),
		.q(md_q)
	);

	assign q_w = SUM_W'(md_q);
	assign vel_w = SUM_W'(vel_q);

	always_comb begin
		conv_val = md_q;
		if (rev_q) begin
			case (kind_q) inside
				KIND_ENCODER, KIND_IME: conv_val = sat48(-q_w);
				KIND_POT: conv_val = sat48(POT_FULL - q_w);
				KIND_LIGHT: conv_val = sat48(LIGHT_FULL - q_w);
				default: conv_val = md_q;
			endcase
		end
	end

	assign vel_sum = q_w + (vel_w <<< 1) + vel_w;
	assign acc_sum = q_w + SUM_W'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			prev_q <= '0;
			hist_q <= 1'b0;
			vel_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit_conv) begin
				newest_q <= conv_val;
				prev_q <= hist_q ? newest_q : conv_val;
				hist_q <= 1'b1;
			end
			if (cmd.commit_acc) begin
				vel_q <= vel_new_q;
				acc_q <= sat48(acc_sum >>> 1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= s_tdata[RAW_W-1:0];
			dt_q <= (s_tdata[RAW_W+DT_W-1:RAW_W] == '0) ? DT_W'(1)
				: s_tdata[RAW_W+DT_W-1:RAW_W];
		end
		if (cmd.commit_conv) begin
			value_q <= conv_val;
		end
		if (cmd.commit_vel) begin
			vel_new_q <= sat48(vel_sum >>> 2);
		end
		if (cmd.load_out) begin
			out_data_q <= {acc_q, vel_q, value_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign stat.md_done = md_done;
	assign stat.out_busy = out_valid_q && !m_tready;
endmodule

// File: src/sva_ctrl.sv
// Controller state machine sequencing conversion, velocity and acceleration steps.
module sva_ctrl
	import sva_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input sva_stat_t stat,
	output sva_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_CONV_W = 3'd2;
	localparam logic [2:0] ST_VEL = 3'd3;
	localparam logic [2:0] ST_VEL_W = 3'd4;
	localparam logic [2:0] ST_ACC = 3'd5;
	localparam logic [2:0] ST_ACC_W = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.md_sel = SEL_CONV;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.md_start = 1'b1;
				state_d = ST_CONV_W;
			end
			ST_CONV_W: begin
				if (stat.md_done) begin
					cmd.commit_conv = 1'b1;
					state_d = ST_VEL;
				end
			end
			ST_VEL: begin
				cmd.md_sel = SEL_VEL;
				cmd.md_start = 1'b1;
				state_d = ST_VEL_W;
			end
			ST_VEL_W: begin
				cmd.md_sel = SEL_VEL;
				if (stat.md_done) begin
					cmd.commit_vel = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.md_sel = SEL_ACC;
				cmd.md_start = 1'b1;
				state_d = ST_ACC_W;
			end
			ST_ACC_W: begin
				cmd.md_sel = SEL_ACC;
				if (stat.md_done) begin
					cmd.commit_acc = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
endmodule

// File: src/sensor_velocity_accel_estimator.sv
// Top level of the sensor velocity and acceleration estimator.
// Each input transaction carries a raw reading and the elapsed milliseconds and yields one
// output transaction with the converted value, the filtered velocity in rpm and the filtered
// acceleration, all signed with 16 fraction bits. One item is processed at a time: three
// passes through one shared serial multiply-divide unit (conversion, velocity, acceleration),
// each a start, 41 multiply steps, 91 divide steps and a commit, then a load of the output
// register. The next input transaction is accepted only after the previous result has been
// loaded into the output register; a stalled output delays that load. A finished result
// waits in the output register while the next input transaction is accepted.
// Configuration writes are always accepted.
module sensor_velocity_accel_estimator
	import sva_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [RAW_W+DT_W-1:0] s_tdata, // raw_sample[31:0], delta_ms[47:32]
	output logic m_tvalid,
	input logic m_tready,
	output logic [3*VAL_W-1:0] m_tdata, // sample_value[47:0], velocity_rpm[95:48], acceleration[143:96]
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);
	sva_cmd_t cmd;
	sva_stat_t stat;

	assign cfg_ready = 1'b1;

	sva_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	sva_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.cmd(cmd),
		.stat(stat)
	);
endmodule

// File: src/sva_checker.sv
// Port-level checks of the estimator and their bind to the top level.
`include "sensor_velocity_accel_estimator_macros.svh"

module sva_checker
	import sva_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [3*VAL_W-1:0] m_tdata,
	input logic cfg_valid,
	input logic cfg_ready
);
	`SVAE_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Output transaction dropped or changed while stalled.")
	`SVAE_CHECK(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "Input accepted again before the current item finished.")
	`SVAE_CHECK(a_no_instant_out, s_tvalid && s_tready |=> !$rose(m_tvalid), "Result appeared in the cycle after input acceptance.")
	`SVAE_CHECK_ALWAYS(a_cfg_ready, cfg_valid |-> cfg_ready, "Configuration write was not accepted.")
endmodule

bind sensor_velocity_accel_estimator sva_checker u_sva_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
